[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TCR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Condition that must never hold at a rising clock edge outside reset.
`define TCR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

[hdl/tcr_pkg.sv]
// Types, constants and character helpers for the token class recogniser.
package tcr_pkg;

  // Number prefix scanner states.
  typedef enum logic [3:0] {
    SC_START = 4'd0,
    SC_SIGN  = 4'd1,
    SC_DOT   = 4'd2,
    SC_I     = 4'd3,
    SC_IN    = 4'd4,
    SC_N     = 4'd5,
    SC_NA    = 4'd6,
    SC_YES   = 4'd7,
    SC_NO    = 4'd8
  } scan_e;

  // Token class codes, in priority order.
  typedef enum logic [3:0] {
    CLS_NUMBER     = 4'd0,
    CLS_COMPARATOR = 4'd1,
    CLS_SIGN       = 4'd2,
    CLS_STRING     = 4'd3,
    CLS_ASTERISK   = 4'd4,
    CLS_IDENT      = 4'd5,
    CLS_SEMICOLON  = 4'd6,
    CLS_NUM_ARRAY  = 4'd7,
    CLS_STR_ARRAY  = 4'd8,
    CLS_UNKNOWN    = 4'd9
  } class_e;

  // State carried from one byte of a token to the next.
  typedef struct packed {
    scan_e      scan;
    logic [7:0] first_byte;
    logic [1:0] length_seen;
    logic       name_ok;
    logic       inner_ok;
  } tok_state_t;

  localparam tok_state_t TokStateReset = '{
    scan:        SC_START,
    first_byte:  8'd0,
    length_seen: 2'd0,
    name_ok:     1'b1,
    inner_ok:    1'b1
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
  endfunction

  // First character of the number proper, after any sign.
  function automatic scan_e scan_begin(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    if (is_digit(c)) return SC_YES;
    if (c == ".") return SC_DOT;
    if (l == "i") return SC_I;
    if (l == "n") return SC_N;
    return SC_NO;
  endfunction

  // One step of the number prefix scanner.
  function automatic scan_e scan_next(input scan_e s, input logic [7:0] c);
    logic [7:0] l;
    scan_e      r;
    l = to_lower(c);
    case (s)
      SC_START: begin
        if (is_space(c)) r = SC_START;
        else if ((c == "+") || (c == "-")) r = SC_SIGN;
        else r = scan_begin(c);
      end
      SC_SIGN: r = scan_begin(c);
      SC_DOT:  r = is_digit(c) ? SC_YES : SC_NO;
      SC_I:    r = (l == "n") ? SC_IN : SC_NO;
      SC_IN:   r = (l == "f") ? SC_YES : SC_NO;
      SC_N:    r = (l == "a") ? SC_NA : SC_NO;
      SC_NA:   r = (l == "n") ? SC_YES : SC_NO;
      SC_YES:  r = SC_YES;
      default: r = SC_NO;
    endcase
    return r;
  endfunction

endpackage

[hdl/token_class_recognizer.sv]
// Token class recogniser top level: input register, classifier and result register.
//
// Usage: a query-language token arrives one byte per transfer on the input
// channel (char_code_i, with is_last_i high on its final byte). The block
// returns one class code on the output channel for each token, on the
// transfer that follows the token's last byte; other bytes give no result.
// Both channels transfer on a clock edge where valid is high and stall low.
// A token's class is formed as its last byte leaves the input register, and
// is held in the result register, which drives out_valid_o.
// Throughput: one byte per cycle while in_stall_o is low, set by the combinational
// classifier that updates the token state between the two registers.
// When the receiver stalls, the result register holds its class; the input
// register keeps taking bytes that give no result, and stalls the sender
// only when it holds a last byte that cannot yet move into the result
// register.
// Reset (rst_ni low) empties both registers and returns the token state to
// its start, so the next byte begins a new token.
module token_class_recognizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_class_o
);

  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                last_q;
  tcr_pkg::tok_state_t state_q;
  tcr_pkg::tok_state_t state_d;
  tcr_pkg::class_e     class_d;
  logic                out_valid_q;
  logic [3:0]          class_q;
  logic                out_free;
  logic                advance;
  logic                in_take;

  // Handshake control.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= is_last_i;
    end
  end

  // Classifier.
  tcr_classify u_classify (
    .state_i (state_q),
    .char_i  (char_q),
    .last_i  (last_q),
    .state_o (state_d),
    .class_o (class_d)
  );

  // Token state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcr_pkg::TokStateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && last_q) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_class_o = class_q;

endmodule

[hdl/tcr_classify.sv]
// Per-byte state update and token class decision.
module tcr_classify (
  input  tcr_pkg::tok_state_t state_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output tcr_pkg::tok_state_t state_o,
  output tcr_pkg::class_e     class_o
);

  logic                first;
  logic [7:0]          fb;
  logic [1:0]          len;
  tcr_pkg::scan_e      scan;
  logic                name;
  logic                len_one;
  logic                len_two;
  logic                bracket;
  tcr_pkg::tok_state_t upd;

  // Values seen with this byte included.
  always_comb begin
    first   = (state_i.length_seen == 2'd0);
    fb      = first ? char_i : state_i.first_byte;
    len     = (state_i.length_seen == 2'd3) ? 2'd3 : (state_i.length_seen + 2'd1);
    scan    = tcr_pkg::scan_next(state_i.scan, char_i);
    name    = first ? (tcr_pkg::is_alpha(char_i) || (char_i == "_"))
                    : (state_i.name_ok && (tcr_pkg::is_alnum(char_i) ||
                                           (char_i == "_") || (char_i == ".")));
    len_one = (len == 2'd1);
    len_two = (len == 2'd2);
    bracket = (len != 2'd1) && (fb == "[") && (char_i == "]");
  end

  // State for the next byte; the token end returns everything to reset.
  always_comb begin
    upd             = state_i;
    upd.scan        = scan;
    upd.first_byte  = fb;
    upd.length_seen = len;
    upd.name_ok     = name;
    if (!first && !(tcr_pkg::is_alnum(char_i) || (char_i == ","))) begin
      upd.inner_ok = 1'b0;
    end
    state_o = last_i ? tcr_pkg::TokStateReset : upd;
  end

  // Class tests in priority order.
  always_comb begin
    if (scan == tcr_pkg::SC_YES) begin
      class_o = tcr_pkg::CLS_NUMBER;
    end else if ((len_one && ((char_i == "<") || (char_i == ">") || (char_i == "="))) ||
                 (len_two && (((fb == "<") && ((char_i == "=") || (char_i == ">"))) ||
                              ((fb == ">") && (char_i == "="))))) begin
      class_o = tcr_pkg::CLS_COMPARATOR;
    end else if (len_one && ((char_i == "+") || (char_i == "-"))) begin
      class_o = tcr_pkg::CLS_SIGN;
    end else if (((fb == "'") && (char_i == "'")) || ((fb == "\"") && (char_i == "\""))) begin
      class_o = tcr_pkg::CLS_STRING;
    end else if (len_one && (char_i == "*")) begin
      class_o = tcr_pkg::CLS_ASTERISK;
    end else if (name) begin
      class_o = tcr_pkg::CLS_IDENT;
    end else if (len_one && (char_i == ";")) begin
      class_o = tcr_pkg::CLS_SEMICOLON;
    end else if (bracket && state_i.inner_ok) begin
      class_o = tcr_pkg::CLS_NUM_ARRAY;
    end else if (bracket) begin
      class_o = tcr_pkg::CLS_STR_ARRAY;
    end else begin
      class_o = tcr_pkg::CLS_UNKNOWN;
    end
  end

endmodule

[hdl/tcr_checker.sv]
// Port-level checks for the token class recogniser, bound to the top level.
`include "assert_macros.svh"

module tcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       is_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] token_class_o
);

  // A stalled result stays offered and unchanged.
  `TCR_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(token_class_o)), "stalled result changed")

  // Class codes above unknown are never produced.
  `TCR_ASSERT_NEVER(a_class_range, clk_i, rst_ni, out_valid_o && (token_class_o > 4'd9), "class code out of range")

  // The sender is held back only by a stalled, occupied result register.
  `TCR_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output back-pressure")

  // A fresh result follows a last-byte transfer.
  `TCR_ASSERT(a_result_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && is_last_i, 2), "result without a token end")

endmodule

bind token_class_recognizer tcr_checker u_tcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .is_last_i     (is_last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .token_class_o (token_class_o)
);
